[rtl/tsptc_pkg.sv]
package tsptc_pkg;

  localparam int VERTEX_BITS = 6;
  localparam int INPUT_DIST_BITS = 16;
  localparam int COUNT_BITS = 7;
  localparam int COST_BITS = 22;

  localparam logic [COST_BITS-1:0] COST_MAX = '1;
  localparam logic [COUNT_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TOUR = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [VERTEX_BITS-1:0]     edge_from;
    logic [VERTEX_BITS-1:0]     edge_to;
    logic [INPUT_DIST_BITS-1:0] edge_distance;
    logic [VERTEX_BITS-1:0]     tour_vertex;
    logic                       tour_last;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] tour_cost;
    logic                 tour_valid;
  } out_item_t;

  // One access to the edge table: a write or a read of the entry src->dst.
  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [VERTEX_BITS-1:0] src;
    logic [VERTEX_BITS-1:0] dst;
  } edge_req_t;

  typedef struct packed {
    logic in_range;
    logic repeat_hit;
  } visit_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CLOSE
  } state_t;

endpackage

[rtl/tsp_tour_cost_check_core.sv]
// Edge-write beat: written in the idle state. Tour-vertex beat: the edge-table and visited-map
// reads, then the check and accumulate in ST_STEP. Final vertex: ST_STEP issues the closing
// read and ST_CLOSE registers the result, as the step and closing reads on the single-port
// edge memory are dependent. After every 15th tour the visited map is swept with in_ready low.
// Reset: a clearing pass over all MAX_VERTICES*MAX_VERTICES entries (4096 by default) marks
// all edges invalid; in_ready stays low during it, configuration writes are taken throughout.
module tsp_tour_cost_check_core #(
  parameter int MAX_VERTICES  = 64,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsptc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsptc_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data
);

  localparam int CB = tsptc_pkg::COST_BITS;
  localparam int SW = ((DISTANCE_BITS > CB) ? DISTANCE_BITS : CB) + 1;

  tsptc_pkg::state_t    state_r, state_nxt;
  logic [5:0]           first_r, first_nxt;
  logic [5:0]           prev_r, prev_nxt;
  logic [6:0]           pos_r, pos_nxt;
  logic [CB-1:0]        cost_r, cost_nxt;
  logic                 broken_r, broken_nxt;
  logic                 last_r, last_nxt;
  logic                 look_r, look_nxt;
  logic [6:0]           vcount_r;
  logic                 out_valid_r, out_valid_nxt;
  tsptc_pkg::out_item_t out_data_r, out_data_nxt;

  tsptc_pkg::edge_req_t   req;
  tsptc_pkg::visit_stat_t vstat;
  logic [DISTANCE_BITS+15:0] dist_ext;
  logic [DISTANCE_BITS-1:0]  wr_dist;
  logic                      rd_valid;
  logic [DISTANCE_BITS-1:0]  rd_dist;
  logic                      busy;
  logic                      visit_busy;
  logic                      accept;
  logic                      tour_acc;
  logic                      visit_clr;
  logic                      brk;
  logic [CB-1:0]             cost_add;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                            input logic [DISTANCE_BITS-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > SW'(tsptc_pkg::COST_MAX)) begin
      return tsptc_pkg::COST_MAX;
    end
    return s[CB-1:0];
  endfunction

  assign in_ready  = (state_r == tsptc_pkg::ST_IDLE) && !busy && !visit_busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept   = in_valid && in_ready;
  assign tour_acc = accept && (in_data.func == tsptc_pkg::FUNC_TOUR);
  assign dist_ext = (DISTANCE_BITS + 16)'(in_data.edge_distance);
  assign wr_dist  = dist_ext[DISTANCE_BITS-1:0];
  assign cost_add = sat_add(cost_r, rd_dist);

  tsptc_edge_mem #(
    .MAX_VERTICES  (MAX_VERTICES),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_edge_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .wr_dist  (wr_dist),
    .rd_valid (rd_valid),
    .rd_dist  (rd_dist),
    .busy     (busy)
  );

  tsptc_visit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_visit (
    .clk    (clk),
    .rst_n  (rst_n),
    .vertex (in_data.tour_vertex),
    .vcount (vcount_r),
    .set_en (tour_acc),
    .clr_en (visit_clr),
    .stat   (vstat),
    .busy   (visit_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    pos_nxt       = pos_r;
    cost_nxt      = cost_r;
    broken_nxt    = broken_r;
    last_nxt      = last_r;
    look_nxt      = look_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    visit_clr     = 1'b0;
    brk           = broken_r;
    req.we        = 1'b0;
    req.re        = 1'b0;
    req.src       = in_data.edge_from;
    req.dst       = in_data.edge_to;
    case (state_r)
      tsptc_pkg::ST_IDLE: begin
        if (accept && in_data.func == tsptc_pkg::FUNC_EDGE) begin
          req.we = 1'b1;
        end else if (tour_acc) begin
          // The vertex check comes back with the edge read, so a lookup for a bad
          // vertex is still issued here and then thrown away by the break.
          look_nxt   = (pos_r != '0) && !broken_r;
          req.re     = look_nxt;
          req.src    = prev_r;
          req.dst    = in_data.tour_vertex;
          if (pos_r == '0) begin
            first_nxt = in_data.tour_vertex;
          end
          prev_nxt  = in_data.tour_vertex;
          pos_nxt   = (pos_r == tsptc_pkg::POS_MAX) ? pos_r : pos_r + 7'd1;
          last_nxt  = in_data.tour_last;
          state_nxt = tsptc_pkg::ST_STEP;
        end
      end
      tsptc_pkg::ST_STEP: begin
        brk = broken_r || !vstat.in_range || vstat.repeat_hit || (look_r && !rd_valid);
        broken_nxt = brk;
        if (look_r && rd_valid) begin
          cost_nxt = cost_add;
        end
        if (last_r) begin
          // Closing edge: from the final vertex back to the first one.
          look_nxt  = !brk;
          req.re    = !brk;
          req.src   = prev_r;
          req.dst   = first_r;
          state_nxt = tsptc_pkg::ST_CLOSE;
        end else begin
          state_nxt = tsptc_pkg::ST_IDLE;
        end
      end
      tsptc_pkg::ST_CLOSE: begin
        brk = broken_r || (look_r && !rd_valid) || !look_r || (pos_r != vcount_r);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.tour_valid = !brk;
          out_data_nxt.tour_cost  = brk ? '0 : cost_add;
          first_nxt  = '0;
          prev_nxt   = '0;
          pos_nxt    = '0;
          cost_nxt   = '0;
          broken_nxt = 1'b0;
          look_nxt   = 1'b0;
          visit_clr  = 1'b1;
          state_nxt  = tsptc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tsptc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsptc_pkg::ST_IDLE;
      first_r     <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      cost_r      <= '0;
      broken_r    <= 1'b0;
      last_r      <= 1'b0;
      look_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vcount_r    <= tsptc_pkg::VCOUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      prev_r      <= prev_nxt;
      pos_r       <= pos_nxt;
      cost_r      <= cost_nxt;
      broken_r    <= broken_nxt;
      last_r      <= last_nxt;
      look_r      <= look_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(req.we || req.re))
    else $error("edge table accessed during clearing pass");

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("edge table read and written in one cycle");

  a_tour_to_step: assert property (@(posedge clk) disable iff (!rst_n)
    tour_acc |=> state_r == tsptc_pkg::ST_STEP)
    else $error("tour beat did not move to the step lookup");

  a_close_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsptc_pkg::ST_CLOSE && $past(state_r) != tsptc_pkg::ST_CLOSE)
      |-> $past(state_r) == tsptc_pkg::ST_STEP && $past(last_r))
    else $error("closing lookup entered without a final vertex");

  a_invalid_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.tour_valid || out_data_r.tour_cost == '0))
    else $error("invalid tour reported with nonzero cost");

endmodule

[rtl/tsptc_edge_mem.sv]
module tsptc_edge_mem #(
  parameter int MAX_VERTICES  = 64,
  parameter int DISTANCE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tsptc_pkg::edge_req_t     req,
  input  logic [DISTANCE_BITS-1:0] wr_dist,
  output logic                     rd_valid,
  output logic [DISTANCE_BITS-1:0] rd_dist,
  output logic                     busy
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW = $clog2(DEPTH);

  logic [DISTANCE_BITS:0] mem [DEPTH];
  logic [DISTANCE_BITS:0] rd_r;
  logic [AW-1:0]          clr_addr_r;
  logic [AW-1:0]          clr_addr_nxt;
  logic                   clearing_r;
  logic                   clearing_nxt;
  logic [AW-1:0]          addr;
  logic                   addr_ok;

  function automatic logic [AW-1:0] edge_addr(input logic [5:0] a, input logic [5:0] b);
    int lin;
    lin = int'(a) * MAX_VERTICES + int'(b);
    return lin[AW-1:0];
  endfunction

  assign addr    = edge_addr(req.src, req.dst);
  assign addr_ok = (int'(req.src) < MAX_VERTICES) && (int'(req.dst) < MAX_VERTICES);

  // After reset every entry is swept to invalid, one entry per cycle.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.we && addr_ok) begin
      mem[addr] <= {1'b1, wr_dist};
    end
    if (req.re && addr_ok) begin
      rd_r <= mem[addr];
    end
  end

  assign rd_valid = rd_r[DISTANCE_BITS];
  assign rd_dist  = rd_r[DISTANCE_BITS-1:0];
  assign busy     = clearing_r;

endmodule

[rtl/tsptc_visit.sv]
module tsptc_visit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [5:0]             vertex,
  input  logic [6:0]             vcount,
  input  logic                   set_en,
  input  logic                   clr_en,
  output tsptc_pkg::visit_stat_t stat,
  output logic                   busy
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = 4;

  // Each entry holds the number of the tour that last visited the vertex. A vertex
  // counts as visited when its entry matches the number of the current tour.
  logic [EW-1:0]  tag_mem [MAX_VERTICES];
  logic [EW-1:0]  tag_rd_r;
  logic           in_range_r;
  logic [EW-1:0]  epoch_r, epoch_nxt;
  logic           sweep_r, sweep_nxt;
  logic [VW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [VW+5:0]  vert_ext;
  logic [VW-1:0]  idx;
  logic           in_range;

  assign vert_ext = (VW + 6)'(vertex);
  assign idx      = vert_ext[VW-1:0];
  assign in_range = ({1'b0, vertex} < vcount) && (int'(vertex) < MAX_VERTICES);

  // The status belongs to the last vertex beat taken and is valid in the next cycle.
  assign stat.in_range   = in_range_r;
  assign stat.repeat_hit = in_range_r && (tag_rd_r == epoch_r);
  assign busy            = sweep_r;

  always_comb begin
    epoch_nxt      = epoch_r;
    sweep_nxt      = sweep_r;
    sweep_addr_nxt = sweep_addr_r;
    if (sweep_r) begin
      if (sweep_addr_r == VW'(MAX_VERTICES - 1)) begin
        sweep_nxt = 1'b0;
      end else begin
        sweep_addr_nxt = sweep_addr_r + VW'(1);
      end
    end else if (clr_en) begin
      if (epoch_r == '1) begin
        // Tour numbers are used up: clear every entry and start over at one.
        epoch_nxt      = EW'(1);
        sweep_nxt      = 1'b1;
        sweep_addr_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r      <= EW'(1);
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
      in_range_r   <= 1'b0;
    end else begin
      epoch_r      <= epoch_nxt;
      sweep_r      <= sweep_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      if (set_en) begin
        in_range_r <= in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      tag_mem[sweep_addr_r] <= '0;
    end else if (set_en && in_range) begin
      tag_mem[idx] <= epoch_r;
    end
    if (set_en && in_range) begin
      tag_rd_r <= tag_mem[idx];
    end
  end

endmodule
